### rtl/core/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms used by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define LKVC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key-value cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic hit;
      logic evict;
   } dir_status_type;

endpackage

### rtl/core/lkvc_channels.sv
// ----------------------------------------------------------------------------
// lkvc channels
// Valid/ready channel interfaces for requests, responses and the CSR write.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic signed [lkvc_pkg::DATA_W-1:0]   key;
   logic signed [lkvc_pkg::DATA_W-1:0]   write_value;

   modport source (output valid, opcode, key, write_value, input ready);
   modport sink   (input valid, opcode, key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic signed [lkvc_pkg::DATA_W-1:0]   read_value;
   logic                                 evicted;

   modport source (output valid, found, read_value, evicted, input ready);
   modport sink   (input valid, found, read_value, evicted, output ready);
endinterface

interface lkvc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [lkvc_pkg::CAP_W-1:0]           capacity_in_use;

   modport source (output valid, capacity_in_use, input ready);
   modport sink   (input valid, capacity_in_use, output ready);
endinterface

### rtl/core/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lkvc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lkvc_dir.sv
// ----------------------------------------------------------------------------
// lkvc_dir
// Key directory: parallel key compare, recency ranks, fill count and the
// choice of the entry that a lookup or update touches.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lkvc_dir #(
   parameter int MAX_ENTRIES = 16,
   parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  look,
   input  logic                                  opcode,
   input  logic [lkvc_pkg::DATA_W-1:0]           key,
   input  logic [lkvc_pkg::CAP_W-1:0]            capacity,
   output logic [IDX_W-1:0]                      slot,
   output lkvc_pkg::dir_status_type              status
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EW    = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   logic [MAX_ENTRIES-1:0]                        valid_ff, valid_in;
   logic [MAX_ENTRIES-1:0][lkvc_pkg::DATA_W-1:0]  key_ff, key_in;
   logic [MAX_ENTRIES-1:0][IDX_W-1:0]             rank_ff, rank_in;
   logic [CNT_W-1:0]                              used_ff, used_in;

   logic [MAX_ENTRIES-1:0] match;
   logic [MAX_ENTRIES-1:0] victim_hot;
   logic [IDX_W-1:0]       hit_slot;
   logic [IDX_W-1:0]       free_slot;
   logic [IDX_W-1:0]       victim_slot;
   logic [IDX_W-1:0]       hit_rank;
   logic [IDX_W-1:0]       limit;
   logic [CNT_W-1:0]       last_full;
   logic [IDX_W-1:0]       last_rank;
   logic [EW-1:0]          cap_ext;
   logic [EW-1:0]          eff_cap;
   logic                   hit;
   logic                   room;
   logic                   fill;
   logic                   upd;
   logic                   age_all;

   always_comb begin
      match       = '0;
      victim_hot  = '0;
      hit_slot    = '0;
      victim_slot = '0;
      free_slot   = '0;
      last_full   = used_ff - CNT_W'(1);
      last_rank   = last_full[IDX_W-1:0];
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]      = valid_ff[i] && (key_ff[i] == key);
         // ranks of valid entries form 0..used-1, so the oldest has used-1
         victim_hot[i] = valid_ff[i] && (rank_ff[i] == last_rank);
         if (match[i]) begin
            hit_slot = hit_slot | IDX_W'(i);
         end
         if (victim_hot[i]) begin
            victim_slot = victim_slot | IDX_W'(i);
         end
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = IDX_W'(i);
         end
      end

      hit      = |match;
      hit_rank = rank_ff[hit_slot];

      // zero acts as one, anything above the store acts as the store size
      cap_ext = EW'(capacity);
      if (capacity == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(MAX_ENTRIES)) begin
         eff_cap = EW'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      room = EW'(used_ff) < eff_cap;

      status.hit   = hit;
      status.evict = (opcode == lkvc_pkg::OP_SET) && !hit && !room;
      fill         = (opcode == lkvc_pkg::OP_SET) && !hit && room;
      upd          = look && (hit || (opcode == lkvc_pkg::OP_SET));
      age_all      = !hit;
      limit        = hit_rank;

      if (hit) begin
         slot = hit_slot;
      end else if (room) begin
         slot = free_slot;
      end else begin
         slot = victim_slot;
      end

      valid_in = valid_ff;
      key_in   = key_ff;
      rank_in  = rank_ff;
      used_in  = used_ff;
      if (upd) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == slot) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (age_all || (rank_ff[i] < limit))) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         if (!hit) begin
            key_in[slot] = key;
         end
         if (fill) begin
            valid_in[slot] = 1'b1;
            used_in        = used_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rank_ff  <= '0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   `LKVC_ASSERT_ALWAYS(a_unique_key, clock, reset, $onehot0(match),
      "more than one entry holds the key")
   `LKVC_ASSERT_ALWAYS(a_fill_count, clock, reset,
      used_ff == CNT_W'($countones(valid_ff)), "fill count disagrees with valid entries")
   `LKVC_ASSERT_IMPLY(a_one_victim, clock, reset, look && status.evict,
      $onehot(victim_hot), "eviction without exactly one oldest entry")

endmodule

### rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Requests pass through accept, lookup-update (with the registered value read)
//   and response load; only one request is in flight, so a new request is not
//   taken until the response is loaded into the output register.
// A finished response waits in the output register while the next request
//   is taken. Reset empties the cache and sets capacity_in_use to 16.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic          clock,
   input  logic          reset,
   lkvc_req_if.sink      req_bus,
   lkvc_rsp_if.source    rsp_bus,
   lkvc_csr_if.sink      csr_bus
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   lkvc_pkg::state_type             state_ff, state_in;
   logic                            req_ready;
   logic                            look;
   logic                            load_rsp;

   logic                            op_ff;
   logic [lkvc_pkg::DATA_W-1:0]     key_ff;
   logic [lkvc_pkg::DATA_W-1:0]     wval_ff;
   logic                            hit_ff;
   logic                            evict_ff;
   logic [lkvc_pkg::CAP_W-1:0]      cap_ff, cap_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            found_ff;
   logic [lkvc_pkg::DATA_W-1:0]     rval_ff;
   logic                            evicted_ff;

   logic [IDX_W-1:0]                slot;
   lkvc_pkg::dir_status_type        status;
   logic [lkvc_pkg::DATA_W-1:0]     ram_rdata;

   lkvc_dir #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dir (
      .clock    (clock),
      .reset    (reset),
      .look     (look),
      .opcode   (op_ff),
      .key      (key_ff),
      .capacity (cap_ff),
      .slot     (slot),
      .status   (status)
   );

   lkvc_ram #(
      .WIDTH (lkvc_pkg::DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (look && (op_ff == lkvc_pkg::OP_SET)),
      .wr_addr (slot),
      .wr_data (wval_ff),
      .rd_en   (look && (op_ff == lkvc_pkg::OP_GET)),
      .rd_addr (slot),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      look         = 1'b0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         lkvc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               state_in = lkvc_pkg::S_LOOK;
            end
         end
         lkvc_pkg::S_LOOK: begin
            look     = 1'b1;
            state_in = lkvc_pkg::S_DONE;
         end
         lkvc_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lkvc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lkvc_pkg::S_IDLE;
         end
      endcase

      cap_in = cap_ff;
      if (csr_bus.valid) begin
         cap_in = csr_bus.capacity_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         op_ff   <= req_bus.opcode;
         key_ff  <= req_bus.key;
         wval_ff <= req_bus.write_value;
      end
      if (look) begin
         hit_ff   <= status.hit;
         evict_ff <= status.evict;
      end
      if (load_rsp) begin
         found_ff   <= hit_ff;
         evicted_ff <= evict_ff;
         rval_ff    <= ((op_ff == lkvc_pkg::OP_GET) && hit_ff) ? ram_rdata
                                                                : lkvc_pkg::MISS_VALUE;
      end
   end

   assign req_bus.ready      = req_ready;
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = found_ff;
   assign rsp_bus.read_value = rval_ff;
   assign rsp_bus.evicted    = evicted_ff;

   `LKVC_ASSERT_IMPLY(a_miss_value, clock, reset, rsp_valid_ff && !found_ff,
      rval_ff == lkvc_pkg::MISS_VALUE, "miss response without all-ones value")
   `LKVC_ASSERT_IMPLY(a_evict_miss, clock, reset, rsp_valid_ff && evicted_ff,
      !found_ff, "eviction reported on a hit")
   `LKVC_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == lkvc_pkg::S_DONE), "response raised outside the done state")

endmodule
